// ----- rtl/call_stack_trace_recorder_macros.svh -----
// assertion macros shared by the call stack trace recorder
`ifndef CALL_STACK_TRACE_RECORDER_MACROS_SVH
`define CALL_STACK_TRACE_RECORDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CSTR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cstr check failed");

// next-cycle implication, checked out of reset
`define CSTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cstr check failed");

`endif

// ----- rtl/cstr_pkg.sv -----
// types, codes and defaults of the call stack trace recorder
package cstr_pkg;

    localparam int DEPTH_LOG2_DEF = 5;
    localparam int XLEN_DEF       = 64;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [11:0] CNT_INDEX = 12'd64;
    localparam logic [11:0] BUF_BASE  = 12'd128;

    typedef struct packed {
        logic [1:0]  action;
        logic        is_call;
        logic        is_return;
        logic [63:0] call_pc;
        logic [63:0] call_next_pc;
        logic [11:0] reg_index;
        logic [63:0] write_value;
    } cstr_req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        recognized;
        logic [4:0]  depth_count;
    } cstr_rsp_t;

    // per-request decode handed from the stack control to the result stage
    typedef struct packed {
        logic recog;
        logic rd_cnt;
        logic rd_buf;
        logic odd;
        logic push;
    } cstr_dec_t;

endpackage

// ----- rtl/call_stack_trace_recorder.sv -----
// top level of the call stack trace recorder
// Records the call chain of a processor for a debugger. Each request is an
// execute event (a call, unless the depth is already at its top value, pushes
// the pair pc / next pc at the current depth and increments it; otherwise a
// return decrements a nonzero depth) or a debug read or write. Debug index 64
// is the depth counter (a write keeps the low DEPTH_LOG2 bits of the data),
// indices from 128 up to 128 + 2*2^DEPTH_LOG2 - 1 read stored words, pc at
// even and next pc at odd indices; a write there has no effect but is
// recognized. Any other index, and the unused action code, answers 0 with
// recognized low. Every request gives exactly one response, with
// depth_count showing the depth after that request.
// Timing: one request per cycle sustained while rsp_stall stays low. A request
// accepted into the input register has the depth counter updated and the
// single-port trace memory written or read there; when the result stage is
// free it moves to the result register together with the registered memory
// data, where its response shows. While a response waits on stall the input
// register takes one more request; after that req_stall holds the input until
// the response drains.
// Reading a stored word that was never written returns undefined data.
module call_stack_trace_recorder
    import cstr_pkg::*;
#(
    parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
    parameter int XLEN       = XLEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  cstr_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output cstr_rsp_t rsp
);

`include "call_stack_trace_recorder_macros.svh"

    // input stage
    logic                  a_valid_reg;
    logic                  a_valid_next;
    cstr_req_t             a_req_reg;
    logic                  a_load;
    logic                  a_adv;

    // result stage
    logic                  b_valid_reg;
    logic                  b_valid_next;
    logic                  b_free;
    cstr_dec_t             b_dec_reg;
    logic [DEPTH_LOG2-1:0] b_cnt_reg;
    logic [DEPTH_LOG2-1:0] b_depth_reg;

    // stack control and memory
    cstr_dec_t             dec;
    logic [DEPTH_LOG2-1:0] depth;
    logic [DEPTH_LOG2-1:0] depth_after;
    logic [DEPTH_LOG2-1:0] slot;
    logic [2*XLEN-1:0]     mem_wdata;
    logic [2*XLEN-1:0]     mem_rdata;
    logic [XLEN-1:0]       word;

    // handshake: result stage frees up when empty or drained this cycle
    assign b_free    = !b_valid_reg || !rsp_stall;
    assign a_adv     = a_valid_reg && b_free;
    assign req_stall = a_valid_reg && !b_free;
    assign a_load    = req_valid && !req_stall;

    assign a_valid_next = a_load || (a_valid_reg && !a_adv);
    assign b_valid_next = a_adv || (b_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_req_reg <= req;
        end
        if (a_adv)
        begin
            b_dec_reg   <= dec;
            b_cnt_reg   <= depth;
            b_depth_reg <= depth_after;
        end
    end

    cstr_stack #(
        .DEPTH_LOG2 (DEPTH_LOG2)
    ) u_stack (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (a_adv),
        .req         (a_req_reg),
        .dec         (dec),
        .depth       (depth),
        .depth_after (depth_after),
        .slot        (slot)
    );

    // entry layout: next pc in the upper half, pc in the lower half
    assign mem_wdata = {a_req_reg.call_next_pc[XLEN-1:0], a_req_reg.call_pc[XLEN-1:0]};

    cstr_mem #(
        .DEPTH_LOG2 (DEPTH_LOG2),
        .WIDTH      (2 * XLEN)
    ) u_mem (
        .clk   (clk),
        .we    (a_adv && dec.push),
        .re    (a_adv && dec.rd_buf),
        .addr  (slot),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // response: pick the word half, the counter value or zero
    assign word = b_dec_reg.odd ? mem_rdata[2*XLEN-1:XLEN] : mem_rdata[XLEN-1:0];

    always_comb
    begin
        rsp.recognized  = b_dec_reg.recog;
        rsp.depth_count = 5'(b_depth_reg);
        if (b_dec_reg.rd_buf)
        begin
            rsp.read_data = 64'(word);
        end
        else if (b_dec_reg.rd_cnt)
        begin
            rsp.read_data = 64'(b_cnt_reg);
        end
        else
        begin
            rsp.read_data = '0;
        end
    end

    assign rsp_valid = b_valid_reg;

    // a held response freezes the depth counter
    `CSTR_ASSERT_NEXT(a_depth_hold, rsp_valid && rsp_stall, $stable(depth))
    // a recorded call moves the depth up by exactly one
    `CSTR_ASSERT_NEXT(a_push_inc, a_adv && dec.push, depth == DEPTH_LOG2'($past(depth) + 1'b1))
    // unrecognized requests never carry read data
    `CSTR_ASSERT_NOW(a_unrec_zero, rsp_valid && !rsp.recognized, rsp.read_data == '0)
    // the memory is never written at the top depth
    `CSTR_ASSERT_NOW(a_no_full_push, a_adv && dec.push, !(&depth))

endmodule

// ----- rtl/cstr_stack.sv -----
// depth counter and request decode of the call stack trace recorder
module cstr_stack
    import cstr_pkg::*;
#(
    parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  cstr_req_t             req,
    output cstr_dec_t             dec,
    output logic [DEPTH_LOG2-1:0] depth,
    output logic [DEPTH_LOG2-1:0] depth_after,
    output logic [DEPTH_LOG2-1:0] slot
);

    logic [DEPTH_LOG2-1:0] depth_reg;
    logic [DEPTH_LOG2-1:0] depth_next;
    logic [11:0]           off;
    logic                  is_cnt;
    logic                  is_buf;
    logic                  full;

    assign full   = &depth_reg;
    assign is_cnt = (req.reg_index == CNT_INDEX);
    assign off    = req.reg_index - BUF_BASE;
    // offset must stay below two words per entry
    assign is_buf = (req.reg_index >= BUF_BASE) && (off[11:DEPTH_LOG2+1] == '0);

    always_comb
    begin
        dec        = '0;
        depth_next = depth_reg;
        dec.odd    = off[0];
        unique case (req.action)
            ACT_EXEC:
            begin
                if (req.is_call && !full)
                begin
                    dec.push   = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
                else if (req.is_return && (depth_reg != '0))
                begin
                    depth_next = depth_reg - 1'b1;
                end
            end
            ACT_READ:
            begin
                dec.recog  = is_cnt || is_buf;
                dec.rd_cnt = is_cnt;
                dec.rd_buf = !is_cnt && is_buf;
            end
            ACT_WRITE:
            begin
                dec.recog = is_cnt || is_buf;
                if (is_cnt)
                begin
                    depth_next = req.write_value[DEPTH_LOG2-1:0];
                end
            end
            default:
            begin
                depth_next = depth_reg;
            end
        endcase
    end

    assign slot        = dec.push ? depth_reg : off[DEPTH_LOG2:1];
    assign depth       = depth_reg;
    assign depth_after = depth_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (adv)
        begin
            depth_reg <= depth_next;
        end
    end

endmodule

// ----- rtl/cstr_mem.sv -----
// trace entry memory, one port, registered read
module cstr_mem
    import cstr_pkg::*;
#(
    parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
    parameter int WIDTH      = 2 * XLEN_DEF
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic                  re,
    input  logic [DEPTH_LOG2-1:0] addr,
    input  logic [WIDTH-1:0]      wdata,
    output logic [WIDTH-1:0]      rdata
);

    localparam int Depth = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0] mem [Depth];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
